/* src/aar_pkg.sv */
// ============================================================================
// aar_pkg
// Shared widths, register codes, transaction types and fixed-point helpers
// for the area-average rescaler.
// ============================================================================
package aar_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int DEF_MAX_DEST_WIDTH = 2048;
    localparam int DEF_ROWS_IN_FLIGHT = 4;

    localparam int XW    = 10;               // source column
    localparam int YW    = 9;                // source row
    localparam int CW    = 13;               // output column, room for overrun
    localparam int RW    = 11;               // output row, room for overrun
    localparam int SRW   = 3;                // slot row
    localparam int STW   = 24;               // step and gain registers
    localparam int BW    = CW + STW;         // raw bound (k+1)*step
    localparam int QW    = XW + FRAC_BITS;   // clamped bound
    localparam int LW    = QW + 1;           // frame edge in Q format
    localparam int PW    = FRAC_BITS + 1;    // portion or weight, up to 1.0
    localparam int ACC_W = 30;
    localparam int PRODW = 8 + PW;
    localparam int FINW  = ACC_W + STW;

    localparam int COLS_PER_PIXEL = 2;
    localparam int MAX_RESULTS    = 4;
    localparam int TQ_DEPTH       = 2;
    localparam int OQ_DEPTH       = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_W          = 24;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [10:0]    RST_SRC_WIDTH  = 11'd640;
    localparam logic [9:0]     RST_SRC_HEIGHT = 10'd225;
    localparam logic [STW-1:0] RST_X_STEP     = 24'd87381;
    localparam logic [STW-1:0] RST_Y_STEP     = 24'd43691;
    localparam logic [STW-1:0] RST_GAIN       = 24'd73728;
    localparam logic [11:0]    RST_DEST_WIDTH = 12'd480;
    localparam logic [10:0]    RST_DEST_HEIGHT = 11'd337;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_GAIN        = 3'd4,
        CFG_DEST_WIDTH  = 3'd5,
        CFG_DEST_HEIGHT = 3'd6
    } t_cfg_idx;

    // Effective (clamped) configuration seen by front and back.
    typedef struct packed {
        logic [10:0]    w;
        logic [9:0]     h;
        logic [STW-1:0] sx;
        logic [STW-1:0] sy;
        logic [STW-1:0] gain;
        logic [11:0]    dw;
        logic [10:0]    dh;
        logic [LW-1:0]  wq;
        logic [LW-1:0]  hq;
    } t_cfg;

    typedef struct packed {
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic           fs;
        logic [XW-1:0]  x;
        logic [YW-1:0]  y;
        logic [CW-1:0]  cx;
        logic [BW-1:0]  bx;
        logic [RW-1:0]  ry;
        logic [BW-1:0]  by;
        logic [SRW-1:0] sr;
    } t_task;

    typedef struct packed {
        logic [9:0]  row;
        logic [10:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_result;

    // Bound clamped one LSB below the frame edge.
    function automatic logic [QW-1:0] edge_clamp(input logic [BW-1:0] v,
                                                 input logic [LW-1:0] lim);
        logic [LW-1:0] lm1;
        lm1 = lim - LW'(1);
        return (v >= BW'(lim)) ? lm1[QW-1:0] : v[QW-1:0];
    endfunction

    // Overlap of one source cell with the interval [qs, qe].
    function automatic logic [PW-1:0] portion(input logic [XW-1:0] pos,
                                              input logic [QW-1:0] qs,
                                              input logic [QW-1:0] qe);
        logic                 at_s;
        logic                 at_e;
        logic [FRAC_BITS-1:0] fs;
        logic [FRAC_BITS-1:0] fe;
        logic [PW-1:0]        res;
        at_s = (pos == qs[QW-1:FRAC_BITS]);
        at_e = (pos == qe[QW-1:FRAC_BITS]);
        fs   = qs[FRAC_BITS-1:0];
        fe   = qe[FRAC_BITS-1:0];
        if (at_s && at_e) begin
            res = (fe >= fs) ? PW'(fe - fs) : '0;
        end else if (at_s) begin
            res = (PW'(1) << FRAC_BITS) - PW'(fs);
        end else if (at_e) begin
            res = PW'(fe);
        end else begin
            res = PW'(1) << FRAC_BITS;
        end
        return res;
    endfunction

endpackage

/* src/aar_ram.sv */
// ============================================================================
// aar_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module aar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/aar_fifo.sv */
// ============================================================================
// aar_fifo
// Small register FIFO with fill count, used between stages.
// ============================================================================
module aar_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wp;
    logic [PTRW-1:0]  r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTRW'(DEPTH - 1)) ? '0 : r_wp + PTRW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTRW'(DEPTH - 1)) ? '0 : r_rp + PTRW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* src/aar_front.sv */
// ============================================================================
// aar_front
// Accepts source pixels, keeps the raster position and walks the first
// output row and column that each pixel touches, then queues the task.
// ============================================================================
module aar_front #(
    parameter int ROWS_IN_FLIGHT = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aar_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_chg,
    input  logic           i_hold,
    input  logic           i_push,
    input  logic [7:0]     i_red,
    input  logic [7:0]     i_green,
    input  logic [7:0]     i_blue,
    input  logic           i_fs,
    output logic           o_full,
    output aar_pkg::t_task o_task,
    output logic           o_task_push,
    input  logic           i_task_full
);
    import aar_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_TRACK = 2'b10
    } t_fstate;

    t_fstate        r_state;
    logic [XW-1:0]  r_px;
    logic [YW-1:0]  r_py;
    logic [XW-1:0]  r_ix;
    logic [YW-1:0]  r_iy;
    logic [7:0]     r_red;
    logic [7:0]     r_green;
    logic [7:0]     r_blue;
    logic           r_fs;
    logic [CW-1:0]  r_cx;
    logic [BW-1:0]  r_bx;
    logic           r_cok;
    logic [RW-1:0]  r_ry;
    logic [BW-1:0]  r_by;
    logic [SRW-1:0] r_sr;
    logic           r_rok;

    logic [BW-1:0]  p_x;
    logic [BW-1:0]  p_y;
    logic [BW-1:0]  c_prev;
    logic [BW-1:0]  r_prev;
    logic           c_restart;
    logic           c_adv;
    logic           y_restart;
    logic           y_adv;
    logic           settled;
    logic           accept;
    logic [XW:0]    nx;
    logic [YW:0]    ny;

    assign o_full  = (r_state != F_IDLE) || i_hold;
    assign accept  = i_push && !o_full;

    // Tracker: cx is the smallest c with (c+1)*step >= pos, held with
    // bx = (cx+1)*step; it restarts from zero when it is past the target.
    assign p_x       = BW'({r_ix, {FRAC_BITS{1'b0}}});
    assign p_y       = BW'({r_iy, {FRAC_BITS{1'b0}}});
    assign c_prev    = r_bx - BW'(i_cfg.sx);
    assign r_prev    = r_by - BW'(i_cfg.sy);
    assign c_restart = !r_cok || ((r_cx != '0) && (c_prev >= p_x));
    assign c_adv     = !c_restart && (r_bx < p_x) && (r_cx < CW'(i_cfg.dw));
    assign y_restart = !r_rok || ((r_ry != '0) && (r_prev >= p_y));
    assign y_adv     = !y_restart && (r_by < p_y) && (r_ry < RW'(i_cfg.dh));
    assign settled   = !c_restart && !c_adv && !y_restart && !y_adv;

    assign o_task_push = (r_state == F_TRACK) && settled && !i_task_full;
    assign nx          = {1'b0, r_ix} + (XW + 1)'(1);
    assign ny          = {1'b0, r_iy} + (YW + 1)'(1);

    always_comb begin
        o_task.red   = r_red;
        o_task.green = r_green;
        o_task.blue  = r_blue;
        o_task.fs    = r_fs;
        o_task.x     = r_ix;
        o_task.y     = r_iy;
        o_task.cx    = r_cx;
        o_task.bx    = r_bx;
        o_task.ry    = r_ry;
        o_task.by    = r_by;
        o_task.sr    = r_sr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_px    <= '0;
            r_py    <= '0;
            r_cok   <= 1'b0;
            r_rok   <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_TRACK;
                    end
                end
                F_TRACK: begin
                    if (c_restart) begin
                        r_cok <= 1'b1;
                    end
                    if (y_restart) begin
                        r_rok <= 1'b1;
                    end
                    if (o_task_push) begin
                        r_state <= F_IDLE;
                        if (nx >= (XW + 1)'(i_cfg.w)) begin
                            r_px <= '0;
                            r_py <= (ny >= (YW + 1)'(i_cfg.h)) ? '0 : ny[YW-1:0];
                        end else begin
                            r_px <= nx[XW-1:0];
                            r_py <= r_iy;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
            if (i_cfg_chg) begin
                r_cok <= 1'b0;
                r_rok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && accept) begin
            r_ix    <= i_fs ? '0 : r_px;
            r_iy    <= i_fs ? '0 : r_py;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_fs    <= i_fs;
        end
        if (r_state == F_TRACK) begin
            if (c_restart) begin
                r_cx <= '0;
                r_bx <= BW'(i_cfg.sx);
            end else if (c_adv) begin
                r_cx <= r_cx + CW'(1);
                r_bx <= r_bx + BW'(i_cfg.sx);
            end
            if (y_restart) begin
                r_ry <= '0;
                r_by <= BW'(i_cfg.sy);
                r_sr <= '0;
            end else if (y_adv) begin
                r_ry <= r_ry + RW'(1);
                r_by <= r_by + BW'(i_cfg.sy);
                r_sr <= (r_sr == SRW'(ROWS_IN_FLIGHT - 1)) ? '0 : r_sr + SRW'(1);
            end
        end
    end

endmodule

/* src/aar_back.sv */
// ============================================================================
// aar_back
// Walks the output pixels a source pixel overlaps, does the weighted
// read-modify-write on the accumulator store and emits finished pixels.
// ============================================================================
module aar_back #(
    parameter int MAX_DEST_WIDTH = 2048,
    parameter int ROWS_IN_FLIGHT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aar_pkg::t_cfg                     i_cfg,
    input  aar_pkg::t_task                    i_task,
    input  logic                              i_task_empty,
    output logic                              o_task_pop,
    input  logic [$clog2(aar_pkg::OQ_DEPTH+1)-1:0] i_out_count,
    output logic                              o_out_push,
    output aar_pkg::t_result                  o_out_data,
    output logic                              o_init_busy
);
    import aar_pkg::*;

    localparam int DEPTH  = ROWS_IN_FLIGHT * MAX_DEST_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int OCW    = $clog2(OQ_DEPTH + 1);
    localparam int ROWS_PP = ROWS_IN_FLIGHT - 1;

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_CLEAR = 10'b0000000010,
        B_ROW   = 10'b0000000100,
        B_COL   = 10'b0000001000,
        B_MUL   = 10'b0000010000,
        B_PROD  = 10'b0000100000,
        B_UPD   = 10'b0001000000,
        B_FIN   = 10'b0010000000,
        B_EMIT  = 10'b0100000000,
        B_DONE  = 10'b1000000000
    } t_bstate;

    t_bstate                  r_state;
    logic                     r_init;
    logic                     r_go_row;
    logic [AW-1:0]            r_clr;
    t_task                    r_t;
    logic [2:0]               r_i;
    logic [RW-1:0]            r_r;
    logic [SRW-1:0]           r_sr;
    logic [BW-1:0]            r_ysr;
    logic [BW-1:0]            r_yer;
    logic [1:0]               r_j;
    logic [CW-1:0]            r_c;
    logic [BW-1:0]            r_xsr;
    logic [BW-1:0]            r_xer;
    logic [PW-1:0]            r_py;
    logic                     r_rs;
    logic                     r_re;
    logic [PW-1:0]            r_px;
    logic                     r_fresh;
    logic                     r_comp;
    logic [AW-1:0]            r_addr;
    logic [PW-1:0]            r_wt;
    logic [2:0][PRODW-1:0]    r_p;
    logic [2:0][ACC_W-1:0]    r_acc;
    logic [2:0][FINW-1:0]     r_fin;
    logic [2:0]               r_n;
    t_result                  r_pend;
    logic                     r_pend_v;

    logic [QW-1:0]            ys;
    logic [QW-1:0]            ye;
    logic [QW-1:0]            xs;
    logic [QW-1:0]            xe;
    logic [XW-1:0]            ysi;
    logic [XW-1:0]            yei;
    logic [XW-1:0]            xsi;
    logic [XW-1:0]            xei;
    logic [XW-1:0]            yx;
    logic [AW-1:0]            slot;
    logic [2:0][7:0]          colv;
    logic [2:0][ACC_W-1:0]    rd;
    logic [2:0][ACC_W-1:0]    upd;
    logic [ACC_W:0]           sum;
    logic [2:0][7:0]          fin8;
    logic [2*PW-1:0]          wprod;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [3*ACC_W-1:0]       ram_rdata;
    logic                     can_start;

    assign ys   = edge_clamp(r_ysr, i_cfg.hq);
    assign ye   = edge_clamp(r_yer, i_cfg.hq);
    assign xs   = edge_clamp(r_xsr, i_cfg.wq);
    assign xe   = edge_clamp(r_xer, i_cfg.wq);
    assign ysi  = ys[QW-1:FRAC_BITS];
    assign yei  = ye[QW-1:FRAC_BITS];
    assign xsi  = xs[QW-1:FRAC_BITS];
    assign xei  = xe[QW-1:FRAC_BITS];
    assign yx   = XW'(r_t.y);
    assign slot = AW'(r_sr) * AW'(MAX_DEST_WIDTH) + AW'(r_c);
    assign colv = {r_t.blue, r_t.green, r_t.red};
    assign rd   = ram_rdata;
    assign wprod = PW'(r_px) * (2 * PW)'(r_py);

    assign can_start   = !i_task_empty && (i_out_count <= OCW'(OQ_DEPTH - MAX_RESULTS));
    assign o_task_pop  = (r_state == B_IDLE) && can_start;
    assign o_init_busy = r_init;

    // Accumulate with saturation; the first touch of a pixel overwrites.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum = r_fresh ? (ACC_W + 1)'(r_p[k])
                          : {1'b0, rd[k]} + (ACC_W + 1)'(r_p[k]);
            upd[k] = (sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fin8[k] = (|r_fin[k][FINW-1:2*FRAC_BITS+8]) ? 8'hFF
                                                       : r_fin[k][2*FRAC_BITS +: 8];
        end
    end

    assign ram_we    = (r_state == B_CLEAR) || (r_state == B_UPD);
    assign ram_waddr = (r_state == B_CLEAR) ? r_clr : r_addr;

    aar_ram #(
        .WIDTH (3 * ACC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ((r_state == B_CLEAR) ? '0 : upd),
        .i_re    (r_state == B_COL),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_out_push = 1'b0;
        o_out_data = r_pend;
        if (r_pend_v && (r_state == B_EMIT || r_state == B_DONE)) begin
            o_out_push      = 1'b1;
            o_out_data.last = (r_state == B_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_init   <= 1'b1;
            r_go_row <= 1'b0;
            r_clr    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (can_start) begin
                        r_pend_v <= 1'b0;
                        r_go_row <= 1'b1;
                        r_clr    <= '0;
                        r_state  <= i_task.fs ? B_CLEAR : B_ROW;
                    end
                end
                B_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_go_row ? B_ROW : B_IDLE;
                    end
                end
                B_ROW: begin
                    if (r_i == 3'(ROWS_PP) || r_r >= RW'(i_cfg.dh) || ysi > yx) begin
                        r_state <= B_DONE;
                    end else if (yei >= yx) begin
                        r_state <= B_COL;
                    end
                end
                B_COL: begin
                    if (r_j == 2'(COLS_PER_PIXEL) || r_c >= CW'(i_cfg.dw) ||
                        xsi > r_t.x) begin
                        r_state <= B_ROW;
                    end else if (xei >= r_t.x) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL:  r_state <= B_PROD;
                B_PROD: r_state <= B_UPD;
                B_UPD:  r_state <= (r_comp && r_n < 3'(MAX_RESULTS)) ? B_FIN : B_COL;
                B_FIN:  r_state <= B_EMIT;
                B_EMIT: begin
                    r_pend_v <= 1'b1;
                    r_state  <= B_COL;
                end
                B_DONE: begin
                    r_pend_v <= 1'b0;
                    r_go_row <= 1'b0;
                    r_state  <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_t   <= i_task;
                r_i   <= '0;
                r_r   <= i_task.ry;
                r_sr  <= i_task.sr;
                r_ysr <= i_task.by - BW'(i_cfg.sy);
                r_yer <= i_task.by;
                r_n   <= '0;
            end
            B_ROW: begin
                if (yei < yx) begin
                    // row ends above this pixel: skip it
                    r_i   <= r_i + 3'(1);
                    r_r   <= r_r + RW'(1);
                    r_sr  <= (r_sr == SRW'(ROWS_IN_FLIGHT - 1)) ? '0 : r_sr + SRW'(1);
                    r_ysr <= r_yer;
                    r_yer <= r_yer + BW'(i_cfg.sy);
                end else begin
                    r_py  <= portion(yx, ys, ye);
                    r_rs  <= (yx == ysi);
                    r_re  <= (yx == yei);
                    r_j   <= '0;
                    r_c   <= r_t.cx;
                    r_xsr <= r_t.bx - BW'(i_cfg.sx);
                    r_xer <= r_t.bx;
                end
            end
            B_COL: begin
                if (r_j == 2'(COLS_PER_PIXEL) || r_c >= CW'(i_cfg.dw) ||
                    xsi > r_t.x) begin
                    r_i   <= r_i + 3'(1);
                    r_r   <= r_r + RW'(1);
                    r_sr  <= (r_sr == SRW'(ROWS_IN_FLIGHT - 1)) ? '0 : r_sr + SRW'(1);
                    r_ysr <= r_yer;
                    r_yer <= r_yer + BW'(i_cfg.sy);
                end else if (xei < r_t.x) begin
                    r_j   <= r_j + 2'(1);
                    r_c   <= r_c + CW'(1);
                    r_xsr <= r_xer;
                    r_xer <= r_xer + BW'(i_cfg.sx);
                end else begin
                    r_px    <= portion(r_t.x, xs, xe);
                    r_fresh <= r_rs && (r_t.x == xsi);
                    r_comp  <= r_re && (r_t.x == xei);
                    r_addr  <= slot;
                end
            end
            B_MUL: begin
                r_wt <= wprod[FRAC_BITS +: PW];
            end
            B_PROD: begin
                for (int k = 0; k < 3; k++) begin
                    r_p[k] <= PRODW'(colv[k]) * r_wt;
                end
            end
            B_UPD: begin
                r_acc <= upd;
                if (!(r_comp && r_n < 3'(MAX_RESULTS))) begin
                    r_j   <= r_j + 2'(1);
                    r_c   <= r_c + CW'(1);
                    r_xsr <= r_xer;
                    r_xer <= r_xer + BW'(i_cfg.sx);
                end
            end
            B_FIN: begin
                for (int k = 0; k < 3; k++) begin
                    r_fin[k] <= FINW'(r_acc[k]) * FINW'(i_cfg.gain);
                end
            end
            B_EMIT: begin
                r_pend.row   <= r_r[9:0];
                r_pend.col   <= r_c[10:0];
                r_pend.red   <= fin8[0];
                r_pend.green <= fin8[1];
                r_pend.blue  <= fin8[2];
                r_pend.last  <= 1'b0;
                r_n          <= r_n + 3'(1);
                r_j          <= r_j + 2'(1);
                r_c          <= r_c + CW'(1);
                r_xsr        <= r_xer;
                r_xer        <= r_xer + BW'(i_cfg.sx);
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/area_average_rescaler_core.sv */
// ============================================================================
// area_average_rescaler_core
// Area-averaging RGB rescaler: source pixels in raster order, averaged
// output pixels out, accumulators kept in a store of output rows.
// ============================================================================
// Pacing: the front takes no new pixel until its first-row/first-column walk
//   has settled and the task is queued; the back passes ROW per output row
//   entered or skipped, COL per column, MUL, PROD and UPD per touched output
//   pixel and FIN and EMIT per finished one, set by the single-port accumulator
//   read-modify-write; it starts a pixel only with 4 free result slots.
// Output: a finished pixel passes MUL, PROD, UPD, FIN and EMIT in the back;
//   each result is then held until the next one of the same pixel is
//   finished or the walk ends, so the last one follows the walk end.
// Reset: registers take their defaults, then a clearing pass over all
//   ROWS_IN_FLIGHT*MAX_DEST_WIDTH store entries zeroes the store with full high.
//   Every frame_start pixel runs the same pass before it is processed.
module area_average_rescaler_core
    import aar_pkg::*;
#(
    parameter int MAX_DEST_WIDTH = aar_pkg::DEF_MAX_DEST_WIDTH,
    parameter int ROWS_IN_FLIGHT = aar_pkg::DEF_ROWS_IN_FLIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [aar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aar_pkg::CFG_W-1:0]       i_cfg_data,
    // source pixel queue side
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_red_in,
    input  logic [7:0]                      i_green_in,
    input  logic [7:0]                      i_blue_in,
    input  logic                            i_frame_start,
    // result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic [9:0]                      o_dest_row,
    output logic [10:0]                     o_dest_col,
    output logic [7:0]                      o_red_out,
    output logic [7:0]                      o_green_out,
    output logic [7:0]                      o_blue_out,
    output logic                            o_last_of_run
);

    localparam int OCW = $clog2(OQ_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers (raw), then the clamped view everyone uses.
    // ------------------------------------------------------------------
    logic [10:0]    r_src_w;
    logic [9:0]     r_src_h;
    logic [STW-1:0] r_x_step;
    logic [STW-1:0] r_y_step;
    logic [STW-1:0] r_gain;
    logic [11:0]    r_dest_w;
    logic [10:0]    r_dest_h;
    logic           r_cfg_chg;
    t_cfg           cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= RST_SRC_WIDTH;
            r_src_h   <= RST_SRC_HEIGHT;
            r_x_step  <= RST_X_STEP;
            r_y_step  <= RST_Y_STEP;
            r_gain    <= RST_GAIN;
            r_dest_w  <= RST_DEST_WIDTH;
            r_dest_h  <= RST_DEST_HEIGHT;
            r_cfg_chg <= 1'b0;
        end else begin
            r_cfg_chg <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SRC_WIDTH:   r_src_w  <= i_cfg_data[10:0];
                    CFG_SRC_HEIGHT:  r_src_h  <= i_cfg_data[9:0];
                    CFG_X_STEP:      r_x_step <= i_cfg_data;
                    CFG_Y_STEP:      r_y_step <= i_cfg_data;
                    CFG_GAIN:        r_gain   <= i_cfg_data;
                    CFG_DEST_WIDTH:  r_dest_w <= i_cfg_data[11:0];
                    CFG_DEST_HEIGHT: r_dest_h <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Zero source sizes and zero steps act as one; sizes beyond the store saturate.
    always_comb begin
        cfg.w    = (r_src_w == '0) ? 11'd1 : (r_src_w > 11'd1024) ? 11'd1024 : r_src_w;
        cfg.h    = (r_src_h == '0) ? 10'd1 : (r_src_h > 10'd512) ? 10'd512 : r_src_h;
        cfg.sx   = (r_x_step == '0) ? STW'(1) : r_x_step;
        cfg.sy   = (r_y_step == '0) ? STW'(1) : r_y_step;
        cfg.gain = r_gain;
        cfg.dw   = (13'(r_dest_w) < 13'(MAX_DEST_WIDTH)) ? r_dest_w
                                                          : 12'(MAX_DEST_WIDTH);
        cfg.dh   = (r_dest_h < 11'd1024) ? r_dest_h : 11'd1024;
        cfg.wq   = LW'({cfg.w, {FRAC_BITS{1'b0}}});
        cfg.hq   = LW'({cfg.h, {FRAC_BITS{1'b0}}});
    end

    // ------------------------------------------------------------------
    // Front: position tracking and classification of each pixel.
    // ------------------------------------------------------------------
    t_task            f_task;
    logic             f_task_push;
    logic             tq_full;
    logic             tq_empty;
    logic             tq_pop;
    logic [$bits(t_task)-1:0] tq_data;
    logic [$clog2(TQ_DEPTH+1)-1:0] tq_count;
    logic             init_busy;

    aar_front #(
        .ROWS_IN_FLIGHT (ROWS_IN_FLIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cfg_chg   (r_cfg_chg),
        .i_hold      (init_busy),
        .i_push      (push),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .i_fs        (i_frame_start),
        .o_full      (full),
        .o_task      (f_task),
        .o_task_push (f_task_push),
        .i_task_full (tq_full)
    );

    // Task queue lets the front run ahead while the back works.
    aar_fifo #(
        .WIDTH ($bits(t_task)),
        .DEPTH (TQ_DEPTH)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_task_push),
        .i_data  (f_task),
        .i_pop   (tq_pop),
        .o_data  (tq_data),
        .o_empty (tq_empty),
        .o_full  (tq_full),
        .o_count (tq_count)
    );

    // ------------------------------------------------------------------
    // Back: accumulator walk and result generation.
    // ------------------------------------------------------------------
    logic                          rq_push;
    t_result                       rq_in;
    logic [$bits(t_result)-1:0]    rq_data;
    logic                          rq_full;
    logic [OCW-1:0]                rq_count;
    t_result                       res;

    aar_back #(
        .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
        .ROWS_IN_FLIGHT (ROWS_IN_FLIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_task       (t_task'(tq_data)),
        .i_task_empty (tq_empty || (tq_count == '0)),
        .o_task_pop   (tq_pop),
        .i_out_count  (rq_count),
        .o_out_push   (rq_push),
        .o_out_data   (rq_in),
        .o_init_busy  (init_busy)
    );

    // Result queue; the back only starts a pixel when four entries are free,
    // so a push never meets a full queue.
    aar_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .i_pop   (pop),
        .o_data  (rq_data),
        .o_empty (empty),
        .o_full  (rq_full),
        .o_count (rq_count)
    );

    assign res           = t_result'(rq_data);
    assign o_dest_row    = res.row;
    assign o_dest_col    = res.col;
    assign o_red_out     = res.red;
    assign o_green_out   = res.green;
    assign o_blue_out    = res.blue;
    assign o_last_of_run = res.last && !rq_full | res.last;

endmodule
